// File: src/rpqs_pkg.sv
// Shared constants, codes and interface structs for the relative-position query score block.
`timescale 1ns / 1ps

package rpqs_pkg;

  // Sizing
  localparam int HEIGHT_MAX   = 16;
  localparam int WIDTH_MAX    = 16;
  localparam int CHANNELS_MAX = 64;
  localparam int BATCH_MAX    = 4;

  localparam int POS_MAX      = HEIGHT_MAX * WIDTH_MAX;
  localparam int OFF_ROWS     = 2 * HEIGHT_MAX - 1;
  localparam int OFF_COLS     = 2 * WIDTH_MAX - 1;
  localparam int OFF_PLANE    = OFF_ROWS * OFF_COLS;
  localparam int QSTORE_DEPTH = BATCH_MAX * CHANNELS_MAX * POS_MAX;
  localparam int OTABLE_DEPTH = CHANNELS_MAX * OFF_PLANE;

  localparam int Q_AW   = $clog2(QSTORE_DEPTH);
  localparam int A_AW   = $clog2(OTABLE_DEPTH);
  localparam int NCH_W  = $clog2(CHANNELS_MAX + 1);
  localparam int ROW_W  = $clog2(HEIGHT_MAX);
  localparam int COL_W  = $clog2(WIDTH_MAX);
  localparam int OFF_W  = $clog2(OFF_ROWS > OFF_COLS ? OFF_ROWS : OFF_COLS);
  localparam int AREA_W = $clog2(POS_MAX + 1) + 1;

  // Field widths
  localparam int POS_W   = 8;
  localparam int GRID_W  = 5;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SCORE_W = 40;
  localparam int DIV_CNT_W = $clog2(POS_W);

  // Register reset values
  localparam logic [GRID_W-1:0] HEIGHT_RST  = GRID_W'(16);
  localparam logic [GRID_W-1:0] WIDTH_RST   = GRID_W'(16);
  localparam logic [NCH_W-1:0]  CHANNEL_RST = NCH_W'(64);

  // Command codes
  localparam logic [1:0] CMD_LOAD_QUERY = 2'd0;
  localparam logic [1:0] CMD_LOAD_AFF   = 2'd1;
  localparam logic [1:0] CMD_SCORE      = 2'd2;

  // Register indices
  localparam logic [1:0] CFG_HEIGHT   = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;

  typedef struct packed {
    logic                     q_we;
    logic                     a_we;
    logic                     rd_en;
    logic [Q_AW-1:0]          q_addr;
    logic [A_AW-1:0]          a_addr;
    logic signed [DATA_W-1:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

endpackage

// File: src/relative_position_query_scores.sv
// Top level: 2-D relative-position query scores with a sequenced divider and one MAC.
`timescale 1ns / 1ps

// Load requests (query or affinity element) give no result.
// A score request with a valid position: result strobe after two divisions, then one
//   channel a cycle, over the clamped channel count, through the shared MAC, then a drain.
// A score request with a bad position or batch: result strobe the next cycle, busy stays low.
// One score in flight; busy is high until the result is shown. Results cannot be stalled.
// Synchronous reset: sequencer idle, registers 16/16/64; memories are not cleared.

module relative_position_query_scores (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic [1:0]                          batch,
  input  logic [5:0]                          channel,
  input  logic [7:0]                          query_pos,
  input  logic [7:0]                          key_pos,
  input  logic [4:0]                          offset_row,
  input  logic [4:0]                          offset_col,
  input  logic signed [15:0]                  value,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [6:0]                          cfg_data,
  output logic                                done,
  output logic [1:0]                          out_batch,
  output logic [7:0]                          out_query,
  output logic [7:0]                          out_key,
  output logic signed [39:0]                  score,
  output logic                                bad_index
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIVQ  = 6'b000010,
    ST_DIVK  = 6'b000100,
    ST_OFFS  = 6'b001000,
    ST_MAC   = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [rpqs_pkg::GRID_W-1:0] grid_height, grid_width;
  logic [rpqs_pkg::NCH_W-1:0]  channel_count;
  logic [rpqs_pkg::GRID_W-1:0] h_c, w_c;
  logic [rpqs_pkg::NCH_W-1:0]  nch_c;
  logic [rpqs_pkg::AREA_W-1:0] area;

  // request capture and loop state
  logic [1:0]                  b_r;
  logic [7:0]                  qi_r, kj_r;
  logic [rpqs_pkg::ROW_W-1:0]  ir;
  logic [rpqs_pkg::COL_W-1:0]  ic;
  logic [rpqs_pkg::NCH_W-1:0]  k;
  logic [rpqs_pkg::Q_AW-1:0]   q_ptr, q_base, q_load;
  logic [rpqs_pkg::A_AW-1:0]   a_ptr, a_base, a_load;
  logic [rpqs_pkg::OFF_W-1:0]  ar, ac;
  logic                        rd_valid;

  logic accept, is_score, bad_now, q_ok, a_ok, drain_done;

  // divider
  logic                        div_start, div_done;
  logic [rpqs_pkg::POS_W-1:0]  div_dividend, div_quo;
  logic [rpqs_pkg::GRID_W-1:0] div_rem;

  // store and MAC
  rpqs_pkg::store_req_t                st_req;
  rpqs_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [rpqs_pkg::DATA_W-1:0]  q_rdata, a_rdata;
  logic signed [rpqs_pkg::SCORE_W-1:0] acc;
  logic                                mac_pend;

  // clamp the grid and channel registers to their legal ranges
  always_comb begin
    if (grid_height == '0) begin
      h_c = rpqs_pkg::GRID_W'(1);
    end else if (grid_height > rpqs_pkg::GRID_W'(rpqs_pkg::HEIGHT_MAX)) begin
      h_c = rpqs_pkg::GRID_W'(rpqs_pkg::HEIGHT_MAX);
    end else begin
      h_c = grid_height;
    end
    if (grid_width == '0) begin
      w_c = rpqs_pkg::GRID_W'(1);
    end else if (grid_width > rpqs_pkg::GRID_W'(rpqs_pkg::WIDTH_MAX)) begin
      w_c = rpqs_pkg::GRID_W'(rpqs_pkg::WIDTH_MAX);
    end else begin
      w_c = grid_width;
    end
    nch_c = (channel_count > rpqs_pkg::NCH_W'(rpqs_pkg::CHANNELS_MAX))
          ? rpqs_pkg::NCH_W'(rpqs_pkg::CHANNELS_MAX) : channel_count;
  end

  assign area = rpqs_pkg::AREA_W'(h_c) * rpqs_pkg::AREA_W'(w_c);

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign is_score = accept && (cmd == rpqs_pkg::CMD_SCORE);
  assign bad_now  = (rpqs_pkg::AREA_W'(query_pos) >= area)
                 || (rpqs_pkg::AREA_W'(key_pos) >= area)
                 || (32'(batch) >= rpqs_pkg::BATCH_MAX);

  // load addressing; out-of-range loads are dropped
  assign q_ok = (32'(batch) < rpqs_pkg::BATCH_MAX) && (32'(channel) < rpqs_pkg::CHANNELS_MAX)
             && (32'(query_pos) < rpqs_pkg::POS_MAX);
  assign a_ok = (32'(channel) < rpqs_pkg::CHANNELS_MAX) && (32'(offset_row) < rpqs_pkg::OFF_ROWS)
             && (32'(offset_col) < rpqs_pkg::OFF_COLS);

  assign q_load = rpqs_pkg::Q_AW'(batch) * rpqs_pkg::Q_AW'(rpqs_pkg::CHANNELS_MAX * rpqs_pkg::POS_MAX)
                + rpqs_pkg::Q_AW'(channel) * rpqs_pkg::Q_AW'(rpqs_pkg::POS_MAX)
                + rpqs_pkg::Q_AW'(query_pos);
  assign a_load = rpqs_pkg::A_AW'(channel) * rpqs_pkg::A_AW'(rpqs_pkg::OFF_PLANE)
                + rpqs_pkg::A_AW'(offset_row) * rpqs_pkg::A_AW'(rpqs_pkg::OFF_COLS)
                + rpqs_pkg::A_AW'(offset_col);

  // divider runs on i first, then on j; its result registers hold j's row/column afterwards
  assign div_start    = (is_score && !bad_now) || (state == ST_DIVQ && div_done);
  assign div_dividend = (state == ST_DIVQ) ? kj_r : query_pos;

  // relative offset, valid in ST_OFFS
  assign ar = rpqs_pkg::OFF_W'(div_quo[rpqs_pkg::ROW_W-1:0]) + rpqs_pkg::OFF_W'(h_c)
            - rpqs_pkg::OFF_W'(1) - rpqs_pkg::OFF_W'(ir);
  assign ac = rpqs_pkg::OFF_W'(div_rem[rpqs_pkg::COL_W-1:0]) + rpqs_pkg::OFF_W'(w_c)
            - rpqs_pkg::OFF_W'(1) - rpqs_pkg::OFF_W'(ic);
  assign a_base = rpqs_pkg::A_AW'(ar) * rpqs_pkg::A_AW'(rpqs_pkg::OFF_COLS) + rpqs_pkg::A_AW'(ac);
  assign q_base = rpqs_pkg::Q_AW'(b_r) * rpqs_pkg::Q_AW'(rpqs_pkg::CHANNELS_MAX * rpqs_pkg::POS_MAX)
                + rpqs_pkg::Q_AW'(qi_r);

  // memory port: loads while idle, channel walk while in ST_MAC
  always_comb begin
    st_req.q_we   = accept && (cmd == rpqs_pkg::CMD_LOAD_QUERY) && q_ok;
    st_req.a_we   = accept && (cmd == rpqs_pkg::CMD_LOAD_AFF) && a_ok;
    st_req.rd_en  = (state == ST_MAC) && (k < nch_c);
    st_req.q_addr = st_req.rd_en ? q_ptr : q_load;
    st_req.a_addr = st_req.rd_en ? a_ptr : a_load;
    st_req.wdata  = value;
  end

  assign mac_ctrl.clear = (state == ST_OFFS);
  assign mac_ctrl.en    = rd_valid;

  // last product has landed in the accumulator
  assign drain_done = (state == ST_DRAIN) && !rd_valid && !mac_pend;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (is_score && !bad_now) state_next = ST_DIVQ;
      ST_DIVQ:  if (div_done) state_next = ST_DIVK;
      ST_DIVK:  if (div_done) state_next = ST_OFFS;
      ST_OFFS:  state_next = ST_MAC;
      ST_MAC:   if (k == nch_c) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      rd_valid      <= 1'b0;
      grid_height   <= rpqs_pkg::HEIGHT_RST;
      grid_width    <= rpqs_pkg::WIDTH_RST;
      channel_count <= rpqs_pkg::CHANNEL_RST;
    end else begin
      state    <= state_next;
      rd_valid <= st_req.rd_en;
      done     <= is_score && bad_now || drain_done;
      if (cfg_we) begin
        unique case (cfg_index)
          rpqs_pkg::CFG_HEIGHT:   grid_height   <= cfg_data[rpqs_pkg::GRID_W-1:0];
          rpqs_pkg::CFG_WIDTH:    grid_width    <= cfg_data[rpqs_pkg::GRID_W-1:0];
          rpqs_pkg::CFG_CHANNELS: channel_count <= cfg_data[rpqs_pkg::NCH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result registers: bad requests answer straight away, good ones at the end of the drain
  always_ff @(posedge clk) begin
    if (is_score && bad_now) begin
      out_batch <= batch;
      out_query <= query_pos;
      out_key   <= key_pos;
      score     <= '0;
      bad_index <= 1'b1;
    end else if (drain_done) begin
      out_batch <= b_r;
      out_query <= qi_r;
      out_key   <= kj_r;
      score     <= acc;
      bad_index <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_score) begin
      b_r  <= batch;
      qi_r <= query_pos;
      kj_r <= key_pos;
    end
    if (state == ST_DIVQ && div_done) begin
      ir <= div_quo[rpqs_pkg::ROW_W-1:0];
      ic <= div_rem[rpqs_pkg::COL_W-1:0];
    end
    if (state == ST_OFFS) begin
      k     <= '0;
      q_ptr <= q_base;
      a_ptr <= a_base;
    end else if (st_req.rd_en) begin
      k     <= k + rpqs_pkg::NCH_W'(1);
      q_ptr <= q_ptr + rpqs_pkg::Q_AW'(rpqs_pkg::POS_MAX);
      a_ptr <= a_ptr + rpqs_pkg::A_AW'(rpqs_pkg::OFF_PLANE);
    end
  end

  rpqs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (w_c),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  rpqs_store u_store (
    .clk     (clk),
    .req     (st_req),
    .q_rdata (q_rdata),
    .a_rdata (a_rdata)
  );

  rpqs_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .q    (q_rdata),
    .a    (a_rdata),
    .acc  (acc),
    .pend (mac_pend)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a score request is still in flight");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && bad_index |-> score == '0)
    else $error("bad position result carries a non-zero score");

  a_good_starts: assert property (@(posedge clk) disable iff (rst)
    is_score && !bad_now |=> state == ST_DIVQ)
    else $error("valid score request did not start the divider");

endmodule

// File: src/rpqs_div.sv
// Restoring divider, one quotient bit a cycle: splits a flat position into row and column.
`timescale 1ns / 1ps

module rpqs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rpqs_pkg::POS_W-1:0]  dividend,
  input  logic [rpqs_pkg::GRID_W-1:0] divisor,
  output logic                        done,
  output logic [rpqs_pkg::POS_W-1:0]  quo,
  output logic [rpqs_pkg::GRID_W-1:0] rem
);

  logic                              running;
  logic [rpqs_pkg::DIV_CNT_W-1:0]    cnt;
  logic [rpqs_pkg::GRID_W:0]         trial;
  logic                              fits;

  assign trial = {rem, quo[rpqs_pkg::POS_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == rpqs_pkg::DIV_CNT_W'(rpqs_pkg::POS_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // quotient shifts in over the dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      cnt <= '0;
    end else if (running) begin
      quo <= {quo[rpqs_pkg::POS_W-2:0], fits};
      rem <= fits ? rpqs_pkg::GRID_W'(trial - {1'b0, divisor})
                  : rpqs_pkg::GRID_W'(trial);
      cnt <= cnt + rpqs_pkg::DIV_CNT_W'(1);
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("divider restarted while running");

endmodule

// File: src/rpqs_store.sv
// Query store and affinity table memories, one port each, registered reads.
`timescale 1ns / 1ps

module rpqs_store (
  input  logic                               clk,
  input  rpqs_pkg::store_req_t               req,
  output logic signed [rpqs_pkg::DATA_W-1:0] q_rdata,
  output logic signed [rpqs_pkg::DATA_W-1:0] a_rdata
);

  logic signed [rpqs_pkg::DATA_W-1:0] q_mem [rpqs_pkg::QSTORE_DEPTH];
  logic signed [rpqs_pkg::DATA_W-1:0] a_mem [rpqs_pkg::OTABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.q_we) begin
      q_mem[req.q_addr] <= req.wdata;
    end
    if (req.rd_en) begin
      q_rdata <= q_mem[req.q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.a_we) begin
      a_mem[req.a_addr] <= req.wdata;
    end
    if (req.rd_en) begin
      a_rdata <= a_mem[req.a_addr];
    end
  end

endmodule

// File: src/rpqs_mac.sv
// Shared multiply-accumulate: registered product, then a 40-bit accumulator.
`timescale 1ns / 1ps

module rpqs_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  rpqs_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [rpqs_pkg::DATA_W-1:0]  q,
  input  logic signed [rpqs_pkg::DATA_W-1:0]  a,
  output logic signed [rpqs_pkg::SCORE_W-1:0] acc,
  output logic                                pend
);

  logic signed [rpqs_pkg::PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctrl.en;
    end
  end

  // 64 channels of Q4.12 products stay well inside 40 bits: no saturation
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      prod <= q * a;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (pend) begin
      acc <= acc + rpqs_pkg::SCORE_W'(prod);
    end
  end

  a_clear_empty: assert property (@(posedge clk) disable iff (rst) ctrl.clear |-> !pend)
    else $error("accumulator cleared with a product in flight");

endmodule

// File: tb/tb_relative_position_query_scores.sv
// Self-checking testbench for the 2-D relative-position query score block.
`timescale 1ns / 1ps

module tb_relative_position_query_scores;
  import rpqs_pkg::*;

  // Codes the package leaves unnamed: the spare command and the spare register slot.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [15:0] VAL_MIN = 16'h8000;
  localparam logic signed [15:0] VAL_MAX = 16'h7FFF;
  localparam longint SCORE_HI = (64'sd1 <<< 39) - 1;

  // Quiet cycles before a register write, to let loads retire.
  localparam int SETTLE_CYCLES = 8;
  // Final drain; every valid score must have landed by its end.
  localparam int DRAIN_CYCLES = 100;
  // Longest correct quiet spell is the widest request gap plus the slowest score.
  localparam int IDLE_LIMIT = 1000;

  typedef struct {
    logic [1:0]         batch;
    logic [7:0]         query;
    logic [7:0]         key;
    logic signed [39:0] score;
    logic               bad;
  } score_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = CMD_LOAD_QUERY;
  logic [1:0]         batch = '0;
  logic [5:0]         channel = '0;
  logic [7:0]         query_pos = '0;
  logic [7:0]         key_pos = '0;
  logic [4:0]         offset_row = '0;
  logic [4:0]         offset_col = '0;
  logic signed [15:0] value = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_HEIGHT;
  logic [6:0]         cfg_data = '0;
  logic               done;
  logic [1:0]         out_batch;
  logic [7:0]         out_query;
  logic [7:0]         out_key;
  logic signed [39:0] score;
  logic               bad_index;

  relative_position_query_scores dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .batch      (batch),
    .channel    (channel),
    .query_pos  (query_pos),
    .key_pos    (key_pos),
    .offset_row (offset_row),
    .offset_col (offset_col),
    .value      (value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .out_batch  (out_batch),
    .out_query  (out_query),
    .out_key    (out_key),
    .score      (score),
    .bad_index  (bad_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: both stores, with a written flag per entry so
  // that scores only ever read entries that have been loaded, plus the raw
  // register values as written (clamping happens on use, as in the block).
  // ---------------------------------------------------------------------------
  logic signed [15:0] query_mem [QSTORE_DEPTH];
  logic signed [15:0] offset_mem [OTABLE_DEPTH];
  bit                 query_loaded [QSTORE_DEPTH];
  bit                 offset_loaded [OTABLE_DEPTH];
  logic [4:0]         grid_h_reg = 5'd16;
  logic [4:0]         grid_w_reg = 5'd16;
  logic [6:0]         chan_reg = 7'd64;

  score_result_t pending_scores[$];
  int            mismatches = 0;
  int            requests_counted = 0;
  bit            burst_mode = 1'b0;
  int            stall_cycles = 0;

  function automatic int grid_rows();
    int h;
    h = grid_h_reg;
    if (h < 1) h = 1;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    return h;
  endfunction

  function automatic int grid_cols();
    int w;
    w = grid_w_reg;
    if (w < 1) w = 1;
    if (w > WIDTH_MAX) w = WIDTH_MAX;
    return w;
  endfunction

  // A channel count of zero is legal and sums nothing.
  function automatic int active_channels();
    return (int'(chan_reg) > CHANNELS_MAX) ? CHANNELS_MAX : int'(chan_reg);
  endfunction

  function automatic int query_addr(int b, int k, int qi);
    return (b * CHANNELS_MAX + k) * POS_MAX + qi;
  endfunction

  function automatic int offset_addr(int k, int r, int c);
    return (k * OFF_ROWS + r) * OFF_COLS + c;
  endfunction

  // Row offset index of key j seen from query i, biased to be non-negative.
  function automatic int offset_row_of(int qi, int kj);
    return kj / grid_cols() + grid_rows() - 1 - qi / grid_cols();
  endfunction

  function automatic int offset_col_of(int qi, int kj);
    return kj % grid_cols() + grid_cols() - 1 - qi % grid_cols();
  endfunction

  // Biased toward the Q4.12 extremes so the products hit their corners.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic score_result_t predict_score(int b, int qi, int kj);
    score_result_t r;
    int            area;
    int            ar;
    int            ac;
    longint        acc;
    area = grid_rows() * grid_cols();
    acc = 0;
    r.batch = 2'(b);
    r.query = 8'(qi);
    r.key = 8'(kj);
    r.bad = (qi >= area) || (kj >= area) || (b >= BATCH_MAX);
    if (!r.bad) begin
      ar = offset_row_of(qi, kj);
      ac = offset_col_of(qi, kj);
      for (int k = 0; k < active_channels(); k++)
        acc += longint'(query_mem[query_addr(b, k, qi)]) *
               longint'(offset_mem[offset_addr(k, ar, ac)]);
      // only reachable with far more channels than this build has
      if (acc > SCORE_HI) acc = SCORE_HI;
      if (acc < -SCORE_HI - 1) acc = -SCORE_HI - 1;
    end
    r.score = acc[39:0];
    return r;
  endfunction

  // Update the shadow on an accepted request; returns 0 if the block ignores it.
  function automatic bit apply_request(logic [1:0] op, logic [1:0] b, logic [5:0] ch,
                                       logic [7:0] qi, logic [7:0] kj, logic [4:0] orow,
                                       logic [4:0] ocol, logic signed [15:0] val);
    int addr;
    apply_request = 1'b0;
    case (op)
      CMD_LOAD_QUERY:
        if (int'(b) < BATCH_MAX && int'(ch) < CHANNELS_MAX && int'(qi) < POS_MAX) begin
          addr = query_addr(b, ch, qi);
          query_mem[addr] = val;
          query_loaded[addr] = 1'b1;
          apply_request = 1'b1;
        end
      CMD_LOAD_AFF:
        if (int'(ch) < CHANNELS_MAX && int'(orow) < OFF_ROWS && int'(ocol) < OFF_COLS) begin
          addr = offset_addr(ch, orow, ocol);
          offset_mem[addr] = val;
          offset_loaded[addr] = 1'b1;
          apply_request = 1'b1;
        end
      CMD_SCORE: begin
        pending_scores.push_back(predict_score(b, qi, kj));
        apply_request = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Called just after a rising edge; returns on the edge at
  // which the request was taken, leaving start high so a back-to-back request
  // needs no extra edge. Random gaps, with occasional runs of no gap at all.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic [1:0] b, input logic [5:0] ch,
                              input logic [7:0] qi, input logic [7:0] kj,
                              input logic [4:0] orow, input logic [4:0] ocol,
                              input logic signed [15:0] val);
    int gap;
    bit taken;
    if ($urandom_range(0, 24) == 0) burst_mode = !burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= op;
    batch      <= b;
    channel    <= ch;
    query_pos  <= qi;
    key_pos    <= kj;
    offset_row <= orow;
    offset_col <= ocol;
    value      <= val;
    // busy is settled mid-cycle; the request is taken at the edge that follows a low busy
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (apply_request(op, b, ch, qi, kj, orow, ocol, val)) requests_counted++;
  endtask

  // Drop start, let every outstanding score come back, then let loads retire.
  task automatic wait_until_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_scores.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [6:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEIGHT:   grid_h_reg = data[4:0];
      CFG_WIDTH:    grid_w_reg = data[4:0];
      CFG_CHANNELS: chan_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [6:0] h, input logic [6:0] w, input logic [6:0] n);
    wait_until_idle();
    write_register(CFG_HEIGHT, h);
    write_register(CFG_WIDTH, w);
    write_register(CFG_CHANNELS, n);
  endtask

  // Well-formed score: load whatever the score will read that is still
  // missing (and now and then reload what is there), then ask for the score.
  // Caller guarantees qi and kj lie inside the current grid.
  task automatic score_sequence(input int b, input int qi, input int kj);
    int ar;
    int ac;
    ar = offset_row_of(qi, kj);
    ac = offset_col_of(qi, kj);
    for (int k = 0; k < active_channels(); k++) begin
      if (!query_loaded[query_addr(b, k, qi)] || $urandom_range(0, 9) == 0)
        send_request(CMD_LOAD_QUERY, 2'(b), 6'(k), 8'(qi), 8'($urandom), 5'($urandom),
                     5'($urandom), pick_value());
      if (!offset_loaded[offset_addr(k, ar, ac)] || $urandom_range(0, 9) == 0)
        send_request(CMD_LOAD_AFF, 2'($urandom), 6'(k), 8'($urandom), 8'($urandom),
                     5'(ar), 5'(ac), pick_value());
    end
    send_request(CMD_SCORE, 2'(b), 6'($urandom), 8'(qi), 8'(kj), 5'($urandom),
                 5'($urandom), 16'($urandom));
  endtask

  task automatic send_bad_score(input int qi, input int kj);
    send_request(CMD_SCORE, 2'($urandom), 6'($urandom), 8'(qi), 8'(kj), 5'($urandom),
                 5'($urandom), 16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full 16x16 grid, two channels: extreme values, farthest offsets in both
  // directions, ignored loads and the spare command must leave the stores alone.
  task automatic test_directed_extremes();
    set_grid(7'd16, 7'd16, 7'd2);
    send_request(CMD_LOAD_QUERY, 2'd0, 6'd0, 8'd0, 8'd0, 5'd0, 5'd0, VAL_MIN);
    send_request(CMD_LOAD_QUERY, 2'd0, 6'd1, 8'd0, 8'd0, 5'd0, 5'd0, VAL_MIN);
    send_request(CMD_LOAD_AFF, 2'd0, 6'd0, 8'd0, 8'd0, 5'd30, 5'd30, VAL_MIN);
    send_request(CMD_LOAD_AFF, 2'd0, 6'd1, 8'd0, 8'd0, 5'd30, 5'd30, VAL_MIN);
    // top-left query, bottom-right key: largest positive sum
    send_request(CMD_SCORE, 2'd0, 6'd0, 8'd0, 8'd255, 5'd0, 5'd0, 16'sd0);
    send_request(CMD_LOAD_QUERY, 2'd3, 6'd0, 8'd255, 8'd0, 5'd0, 5'd0, VAL_MIN);
    send_request(CMD_LOAD_QUERY, 2'd3, 6'd1, 8'd255, 8'd0, 5'd0, 5'd0, VAL_MAX);
    send_request(CMD_LOAD_AFF, 2'd0, 6'd0, 8'd0, 8'd0, 5'd0, 5'd0, VAL_MAX);
    send_request(CMD_LOAD_AFF, 2'd0, 6'd1, 8'd0, 8'd0, 5'd0, 5'd0, VAL_MAX);
    send_request(CMD_SCORE, 2'd3, 6'd63, 8'd255, 8'd0, 5'd31, 5'd31, VAL_MIN);
    send_request(CMD_LOAD_AFF, 2'd0, 6'd0, 8'd0, 8'd0, 5'd15, 5'd15, VAL_MAX);
    send_request(CMD_LOAD_AFF, 2'd0, 6'd1, 8'd0, 8'd0, 5'd15, 5'd15, VAL_MIN);
    // zero offset from both corners
    send_request(CMD_SCORE, 2'd0, 6'd0, 8'd0, 8'd0, 5'd0, 5'd0, 16'sd0);
    send_request(CMD_SCORE, 2'd3, 6'd0, 8'd255, 8'd255, 5'd0, 5'd0, 16'sd0);
    // affinity loads off the end of the table are dropped
    send_request(CMD_LOAD_AFF, 2'd0, 6'd0, 8'd0, 8'd0, 5'd31, 5'd30, 16'sh1234);
    send_request(CMD_LOAD_AFF, 2'd0, 6'd1, 8'd0, 8'd0, 5'd30, 5'd31, 16'sh1234);
    send_request(CMD_UNUSED, 2'd3, 6'd63, 8'd255, 8'd255, 5'd31, 5'd31, VAL_MIN);
    send_request(CMD_LOAD_QUERY, 2'd2, 6'd63, 8'd128, 8'd255, 5'd31, 5'd31, 16'sh5A5A);
    send_request(CMD_LOAD_AFF, 2'd3, 6'd63, 8'd255, 8'd255, 5'd30, 5'd0, 16'shA5A5);
    send_request(CMD_SCORE, 2'd0, 6'd0, 8'd0, 8'd255, 5'd0, 5'd0, 16'sd0);
  endtask

  // 2x3 grid: positions at and past the area flag bad_index with a zero score.
  task automatic test_grid_bounds();
    set_grid(7'd2, 7'd3, 7'd2);
    send_bad_score(6, 0);
    send_bad_score(0, 6);
    send_bad_score(255, 255);
    score_sequence(1, 5, 0);
    score_sequence(2, 0, 5);
  endtask

  // Out-of-range register values clamp on use; upper data bits are dropped.
  task automatic test_register_clamping();
    wait_until_idle();
    write_register(CFG_HEIGHT, 7'd0);     // clamps up to one row
    write_register(CFG_WIDTH, 7'h7F);     // low five bits 31, clamps to 16
    write_register(CFG_CHANNELS, 7'd0);   // sums nothing
    write_register(CFG_UNUSED, 7'($urandom));
    score_sequence(0, 15, 0);
    score_sequence(3, 0, 15);
    send_bad_score(16, 3);
    wait_until_idle();
    write_register(CFG_HEIGHT, 7'd20);    // clamps to 16 rows
    write_register(CFG_WIDTH, 7'd0);      // clamps to one column
    write_register(CFG_CHANNELS, 7'h7F);  // clamps to every channel
    score_sequence(1, 0, 15);
    score_sequence(1, 0, 7);
    send_bad_score(3, 16);
    set_grid(7'h65, 7'h23, 7'h03);        // five rows, three columns, three channels
    score_sequence(2, 14, 0);
    send_bad_score(15, 15);
  endtask

  // Mostly well-formed scores with random content across a spread of grids;
  // the rest are stray loads, out-of-grid scores and the spare command.
  task automatic test_random_traffic();
    int hs[8]     = '{4, 1, 16, 1, 3, 16, 5, 8};
    int ws[8]     = '{4, 1, 1, 16, 5, 16, 7, 8};
    int ns[8]     = '{4, 3, 8, 8, 6, 3, 1, 12};
    int budget[8] = '{140, 40, 130, 130, 120, 130, 100, 130};
    int target;
    int area;
    int pick;
    int b;
    int qi;
    int kj;
    bit have_last;
    for (int p = 0; p < 8; p++) begin
      set_grid(7'(hs[p]), 7'(ws[p]), 7'(ns[p]));
      area = grid_rows() * grid_cols();
      target = requests_counted + budget[p];
      have_last = 1'b0;
      b = 0;
      qi = 0;
      while (requests_counted < target) begin
        pick = $urandom_range(0, 99);
        if (pick >= 88 && pick < 96 && area == POS_MAX) pick = 0;
        if (pick < 70) begin
          // half the time keep the query column so only the affinity side is new
          if (!have_last || $urandom_range(0, 1) == 0) begin
            b = $urandom_range(0, BATCH_MAX - 1);
            qi = $urandom_range(0, area - 1);
            have_last = 1'b1;
          end
          kj = $urandom_range(0, area - 1);
          score_sequence(b, qi, kj);
        end else if (pick < 80) begin
          send_request(CMD_LOAD_QUERY, 2'($urandom), 6'($urandom), 8'($urandom),
                       8'($urandom), 5'($urandom), 5'($urandom), pick_value());
        end else if (pick < 88) begin
          send_request(CMD_LOAD_AFF, 2'($urandom), 6'($urandom), 8'($urandom),
                       8'($urandom), 5'($urandom), 5'($urandom), pick_value());
        end else if (pick < 96) begin
          case ($urandom_range(0, 2))
            0:       send_bad_score($urandom_range(area, 255), $urandom_range(0, 255));
            1:       send_bad_score($urandom_range(0, 255), $urandom_range(area, 255));
            default: send_bad_score($urandom_range(area, 255), $urandom_range(area, 255));
          endcase
        end else begin
          send_request(CMD_UNUSED, 2'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
                       5'($urandom), 5'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: the strobe lasts one cycle and cannot be held off, so the
  // result is taken at the edge that ends its cycle and matched to the oldest
  // outstanding score request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    score_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("unrequested result, query", out_query, 0);
      end else begin
        want = pending_scores.pop_front();
        if (out_batch !== want.batch) report_mismatch("out_batch", out_batch, want.batch);
        if (out_query !== want.query) report_mismatch("out_query", out_query, want.query);
        if (out_key !== want.key) report_mismatch("out_key", out_key, want.key);
        if (score !== want.score) report_mismatch("score", score, want.score);
        if (bad_index !== want.bad) report_mismatch("bad_index", bad_index, want.bad);
      end
    end
  end

  // Watchdog: any stretch this long with no request, result or register
  // write taken means the block has hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1 || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_grid_bounds();
    test_register_clamping();
    test_random_traffic();
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_scores.size() != 0)
      report_mismatch("scores never returned", pending_scores.size(), 0);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
